FILE: hdl/sla_pkg.sv
// Shared types, constants and helper functions of the select-link OD accumulator.
package sla_pkg;

  // Sizing of the accumulator.
  localparam int NUM_CLASSES = 10;
  localparam int MAX_ZONES   = 64;
  localparam int MAT_DEPTH   = NUM_CLASSES * MAX_ZONES * MAX_ZONES;
  localparam int ADDR_W      = $clog2(MAT_DEPTH);

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int ZONE_W  = 7;
  localparam int CLS_W   = 4;
  localparam int VOL_W   = 24;
  localparam int NODE_W  = 32;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 2;

  // Input commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 3'd0,
    CMD_VOLUME = 3'd1,
    CMD_NODE   = 3'd2,
    CMD_END    = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK1_FROM = 2'd0,
    REG_LINK1_TO   = 2'd1,
    REG_LINK2_FROM = 2'd2,
    REG_LINK2_TO   = 2'd3
  } cfg_reg_t;

  // Link pair matcher states.
  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_FROM = 3'b010,
    P_TO   = 3'b100
  } pair_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_RD_WAIT = 5'b00100,
    S_CM_RD   = 5'b01000,
    S_CM_WR   = 5'b10000
  } state_t;

  // One result transaction.
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              route_matched;
    logic              zone_error;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic              accept;
    logic              push_now;
    logic              push_pend;
    logic              cm_rd;
    logic              cm_wr;
    logic              clr_wr;
    logic [ADDR_W-1:0] clr_addr;
    logic [CLS_W-1:0]  cls;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic skid_free;
    logic is_read;
    logic commit_ok;
  } dp_stat_t;

  // True for a one-based zone in range.
  function automatic logic zone_ok(input logic [ZONE_W-1:0] z);
    return (z != '0) && (32'(z) <= 32'(MAX_ZONES));
  endfunction

  // Matrix address of class c, origin o, destination d (zones one-based).
  function automatic logic [ADDR_W-1:0] mat_addr(input logic [CLS_W-1:0] c,
                                                 input logic [ZONE_W-1:0] o,
                                                 input logic [ZONE_W-1:0] d);
    logic [ADDR_W-1:0] oa;
    logic [ADDR_W-1:0] da;
    oa = ADDR_W'(o) - ADDR_W'(1);
    da = ADDR_W'(d) - ADDR_W'(1);
    return ADDR_W'(ADDR_W'(c) * ADDR_W'(MAX_ZONES * MAX_ZONES))
         + ADDR_W'(oa * ADDR_W'(MAX_ZONES)) + da;
  endfunction

endpackage

FILE: hdl/sla_in_if.sv
// Input item channel of the select-link OD accumulator.
interface sla_in_if import sla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ZONE_W-1:0] origin_zone;
  logic [ZONE_W-1:0] dest_zone;
  logic [CLS_W-1:0]  class_index;
  logic [VOL_W-1:0]  volume;
  logic [NODE_W-1:0] node_id;

  modport source (output valid, cmd, origin_zone, dest_zone, class_index, volume, node_id,
                  input ready);
  modport sink   (input valid, cmd, origin_zone, dest_zone, class_index, volume, node_id,
                  output ready);
endinterface

FILE: hdl/sla_out_if.sv
// Result channel of the select-link OD accumulator.
interface sla_out_if import sla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic              route_matched;
  logic              zone_error;

  modport source (output valid, read_value, route_matched, zone_error, input ready);
  modport sink   (input valid, read_value, route_matched, zone_error, output ready);
endinterface

FILE: hdl/sla_cfg_if.sv
// Configuration write channel of the select-link OD accumulator.
interface sla_cfg_if import sla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/sla_ctrl.sv
// Controller state machine: clearing sweep, input acceptance, read wait and commit sequence.
module sla_ctrl import sla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic [CLS_W-1:0]  cls_cnt, cls_cnt_next;
  logic              accept;

  // Take a transaction only when idle and the skid stage is free
  assign in_ready = (state == S_IDLE) && stat.skid_free;
  assign accept   = in_valid && in_ready;

  // Decode next state and datapath commands
  always_comb begin
    state_next   = state;
    clr_cnt_next = clr_cnt;
    cls_cnt_next = cls_cnt;
    cmd          = '0;
    cmd.accept   = accept;
    cmd.clr_addr = clr_cnt;
    cmd.cls      = cls_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr   = 1'b1;
        clr_cnt_next = clr_cnt + ADDR_W'(1);
        if (clr_cnt == ADDR_W'(MAT_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (stat.is_read) begin
            state_next = S_RD_WAIT;
          end else if (stat.commit_ok) begin
            cls_cnt_next = '0;
            state_next   = S_CM_RD;
          end else begin
            cmd.push_now = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        cmd.push_pend = 1'b1;
        state_next    = S_IDLE;
      end
      S_CM_RD: begin
        cmd.cm_rd  = 1'b1;
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        cmd.cm_wr = 1'b1;
        if (cls_cnt == CLS_W'(NUM_CLASSES - 1)) begin
          cmd.push_pend = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cls_cnt_next = cls_cnt + CLS_W'(1);
          state_next   = S_CM_RD;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      cls_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      cls_cnt <= cls_cnt_next;
    end
  end

endmodule

FILE: hdl/sla_datapath.sv
// Datapath: link registers, route matcher, class volumes, OD matrix memory and output buffer.
module sla_datapath import sla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ZONE_W-1:0]    in_origin_zone,
  input  logic [ZONE_W-1:0]    in_dest_zone,
  input  logic [CLS_W-1:0]     in_class_index,
  input  logic [VOL_W-1:0]     in_volume,
  input  logic [NODE_W-1:0]    in_node_id,
  input  ctrl_cmd_t            cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  // Link registers
  logic [NODE_W-1:0] link1_from, link1_to, link2_from, link2_to;

  // Route state
  logic              second_phase, second_phase_next;
  pair_t             pair_state, pair_state_next;
  logic              second_found, second_found_next;
  logic [ZONE_W-1:0] route_origin, route_dest;
  logic [VOL_W-1:0]  class_volumes [NUM_CLASSES];

  // Matrix memory
  logic [DATA_W-1:0] od_matrix [MAT_DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr, cm_addr, in_addr;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W:0]   sum;

  // Pending and output buffering
  res_t res_next, pend, pend_out, new_res, skid;
  logic pend_rd, skid_valid, out_free, push;

  logic [NODE_W-1:0] a, b;
  logic              hit, in_zones_ok, route_zones_ok, rd_ok, is_node;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link1_from <= '0;
      link1_to   <= '0;
      link2_from <= '0;
      link2_to   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINK1_FROM: link1_from <= cfg_data;
        REG_LINK1_TO:   link1_to   <= cfg_data;
        REG_LINK2_FROM: link2_from <= cfg_data;
        REG_LINK2_TO:   link2_to   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode zone checks of the incoming transaction and of the stored route
  assign in_zones_ok    = zone_ok(in_origin_zone) && zone_ok(in_dest_zone);
  assign route_zones_ok = zone_ok(route_origin) && zone_ok(route_dest);
  assign rd_ok          = in_zones_ok && (32'(in_class_index) < 32'(NUM_CLASSES));
  assign is_node        = (in_cmd == CMD_NODE);

  assign stat.skid_free = !skid_valid;
  assign stat.is_read   = (in_cmd == CMD_READ);
  assign stat.commit_ok = (in_cmd == CMD_END) && route_zones_ok && second_found;

  // Step the link pair matcher on a node
  always_comb begin
    a                 = second_phase ? link2_from : link1_from;
    b                 = second_phase ? link2_to : link1_to;
    hit               = 1'b0;
    pair_state_next   = pair_state;
    second_phase_next = second_phase;
    second_found_next = second_found;
    if (!second_found) begin
      unique case (pair_state)
        P_FROM: begin
          if (in_node_id == b) begin
            hit             = 1'b1;
            pair_state_next = P_IDLE;
          end else if (in_node_id != a) begin
            pair_state_next = P_IDLE;
          end
        end
        P_TO: begin
          if (in_node_id == a) begin
            hit             = 1'b1;
            pair_state_next = P_IDLE;
          end else if (in_node_id != b) begin
            pair_state_next = P_IDLE;
          end
        end
        default: begin
          priority if (in_node_id == a) begin
            pair_state_next = P_FROM;
          end else if (in_node_id == b) begin
            pair_state_next = P_TO;
          end else begin
            pair_state_next = P_IDLE;
          end
        end
      endcase
      if (hit) begin
        if (second_phase) begin
          second_found_next = 1'b1;
        end else begin
          second_phase_next = 1'b1;
        end
      end
    end
  end

  // Form the result of the incoming transaction
  always_comb begin
    res_next = '0;
    unique case (in_cmd)
      CMD_START: begin
        res_next.route_matched = 1'b0;
        res_next.zone_error    = !in_zones_ok;
      end
      CMD_NODE: begin
        res_next.route_matched = second_found_next;
      end
      CMD_END: begin
        res_next.route_matched = second_found;
        res_next.zone_error    = !route_zones_ok;
      end
      CMD_READ: begin
        res_next.route_matched = second_found;
        res_next.zone_error    = !in_zones_ok;
      end
      default: begin
        res_next.route_matched = second_found;
      end
    endcase
  end

  // Update route state on accepted transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      second_phase <= 1'b0;
      pair_state   <= P_IDLE;
      second_found <= 1'b0;
      route_origin <= '0;
      route_dest   <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_volumes[CLS_W'(i)] <= '0;
      end
    end else if (cmd.accept) begin
      if (in_cmd == CMD_START) begin
        second_phase <= 1'b0;
        pair_state   <= P_IDLE;
        second_found <= 1'b0;
        route_origin <= in_origin_zone;
        route_dest   <= in_dest_zone;
        for (int i = 0; i < NUM_CLASSES; i++) begin
          class_volumes[CLS_W'(i)] <= '0;
        end
      end else if (in_cmd == CMD_VOLUME) begin
        if (32'(in_class_index) < 32'(NUM_CLASSES)) begin
          class_volumes[in_class_index] <= in_volume;
        end
      end else if (is_node) begin
        second_phase <= second_phase_next;
        pair_state   <= pair_state_next;
        second_found <= second_found_next;
      end
    end
  end

  // Hold the result of a transaction that waits on memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend    <= res_next;
      pend_rd <= (in_cmd == CMD_READ) && rd_ok;
    end
  end

  always_comb begin
    pend_out            = pend;
    pend_out.read_value = pend_rd ? mem_q : '0;
  end

  // Address and data for the matrix memory
  assign in_addr = mat_addr(in_class_index, in_origin_zone, in_dest_zone);
  assign cm_addr = mat_addr(cmd.cls, route_origin, route_dest);
  assign rd_addr = cmd.cm_rd ? cm_addr : in_addr;
  assign mem_re  = cmd.cm_rd || (cmd.accept && stat.is_read && rd_ok);
  assign sum     = {1'b0, mem_q} + (DATA_W + 1)'(class_volumes[cmd.cls]);
  assign mem_we  = cmd.clr_wr || cmd.cm_wr;
  assign wr_addr = cmd.clr_wr ? cmd.clr_addr : cm_addr;
  assign wr_data = cmd.clr_wr ? '0 : (sum[DATA_W] ? '1 : sum[DATA_W-1:0]);

  // Read the matrix with a registered port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= od_matrix[rd_addr];
    end
  end

  // Write the matrix: clearing sweep or saturated commit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      od_matrix[wr_addr] <= wr_data;
    end
  end

  // Output register with a skid stage behind it
  assign push     = cmd.push_now || cmd.push_pend;
  assign new_res  = cmd.push_now ? res_next : pend_out;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (out_free) begin
        out_res <= new_res;
      end else begin
        skid <= new_res;
      end
    end else if (out_free && skid_valid) begin
      out_res <= skid;
    end
  end

endmodule

FILE: hdl/select_link_od_accumulator.sv
// Top level of the select-link OD accumulator: controller, datapath and checks.
//
// Route items are taken one per cycle while idle with the skid stage free: start, class volume,
// path node, unknown commands and any end route that adds nothing. A matrix read waits on the
// registered read port of the OD matrix memory before its result is pushed. An end route of a
// matched route with valid zones runs a commit sequence: the single memory is read and then
// written once per class, with the saturating add between read and write. After reset the block
// runs a clearing pass over all NUM_CLASSES * MAX_ZONES * MAX_ZONES matrix entries, one per
// cycle, during which no item is accepted; configuration writes are taken at any time. Results
// leave through an output register backed by a skid stage.
module select_link_od_accumulator import sla_pkg::*; (
  input logic       clk,
  input logic       rst,
  sla_cfg_if.sink   cfg,
  sla_in_if.sink    items,
  sla_out_if.source results
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  logic      in_ready;
  res_t      out_res;
  logic      out_valid;

  assign cfg.ready   = 1'b1;
  assign items.ready = in_ready;

  // Controller
  sla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // Datapath
  sla_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .in_cmd         (items.cmd),
    .in_origin_zone (items.origin_zone),
    .in_dest_zone   (items.dest_zone),
    .in_class_index (items.class_index),
    .in_volume      (items.volume),
    .in_node_id     (items.node_id),
    .cmd            (ctrl_cmd),
    .stat           (dp_stat),
    .out_valid      (out_valid),
    .out_ready      (results.ready),
    .out_res        (out_res)
  );

  // Drive the result channel
  assign results.valid         = out_valid;
  assign results.read_value    = out_res.read_value;
  assign results.route_matched = out_res.route_matched;
  assign results.zone_error    = out_res.zone_error;

  // No transaction is taken while the matrix is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.clr_wr |-> !items.ready)
    else $error("input accepted during matrix clearing pass");

  // Memory actions and immediate results exclude each other
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl_cmd.push_now, ctrl_cmd.cm_rd, ctrl_cmd.cm_wr, ctrl_cmd.clr_wr}))
    else $error("controller issued conflicting actions");

  // Every commit write follows the read of the same entry
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.cm_wr |-> $past(ctrl_cmd.cm_rd))
    else $error("commit write without preceding read");

endmodule
